### design/ffbv_pkg.sv
// Shared types and constants for the frustum box visibility test.
package ffbv_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int FIELD_W      = 32;
    localparam int SLOT_FIELD_W = 3;
    localparam int COORD_LSB    = SLOT_FIELD_W;
    localparam int S_TDATA_W    = 200;
    localparam int VIS_W        = 2;
    localparam int M_TDATA_W    = 8;
    localparam int AXIS_W       = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic {
        OP_TEST = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [VIS_W-1:0] {
        VIS_INVISIBLE = 2'd0,
        VIS_PARTIAL   = 2'd1,
        VIS_VISIBLE   = 2'd2
    } vis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Marks carried with each product term through the dot-product unit.
    typedef struct packed {
        logic first;      // first term of a dot product
        logic last;       // last term of a dot product
        logic n_vertex;   // dot product belongs to the near corner
        logic final_dot;  // last dot product of the whole test
    } term_tag_t;

    // Dot-product outcome handed back to the sequencer.
    typedef struct packed {
        logic done;
        logic negative;
        logic n_vertex;
        logic final_dot;
    } dot_res_t;

endpackage

### design/ffbv_plane_store.sv
// Plane store: point and normal of each frustum plane, cleared at reset.
module ffbv_plane_store #(
    parameter int PLANE_COUNT = ffbv_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = ffbv_pkg::COORD_WIDTH_DEF,
    parameter int SLOT_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic        [ffbv_pkg::SLOT_FIELD_W-1:0] load_slot,
    input  logic signed [COORD_WIDTH-1:0]        wr_point  [3],
    input  logic signed [COORD_WIDTH-1:0]        wr_normal [3],
    input  logic        [SLOT_W-1:0]             rd_slot,
    input  logic        [ffbv_pkg::AXIS_W-1:0]   rd_axis,
    output logic signed [COORD_WIDTH-1:0]        rd_point,
    output logic signed [COORD_WIDTH-1:0]        rd_normal
);
    import ffbv_pkg::*;

    logic signed [COORD_WIDTH-1:0] point_reg  [PLANE_COUNT][3];
    logic signed [COORD_WIDTH-1:0] normal_reg [PLANE_COUNT][3];
    logic                          slot_ok;

    // Drop loads aimed past the last plane.
    assign slot_ok = (32'(load_slot) < 32'(PLANE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PLANE_COUNT; k++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    point_reg[k][a]  <= '0;
                    normal_reg[k][a] <= '0;
                end
            end
        end
        else if (we && slot_ok)
        begin
            for (int a = 0; a < 3; a++)
            begin
                point_reg[load_slot[SLOT_W-1:0]][a]  <= wr_point[a];
                normal_reg[load_slot[SLOT_W-1:0]][a] <= wr_normal[a];
            end
        end
    end

    assign rd_point  = point_reg[rd_slot][rd_axis];
    assign rd_normal = normal_reg[rd_slot][rd_axis];

endmodule

### design/ffbv_dot_unit.sv
// Shared multiply-accumulate unit: one product term per cycle, exact sum.
module ffbv_dot_unit #(
    parameter int COORD_WIDTH = ffbv_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          term_valid,
    input  ffbv_pkg::term_tag_t           term_tag,
    input  logic signed [COORD_WIDTH-1:0] corner,
    input  logic signed [COORD_WIDTH-1:0] point,
    input  logic signed [COORD_WIDTH-1:0] normal,
    output ffbv_pkg::dot_res_t            res
);
    import ffbv_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 1;
    localparam int AW = 2 * COORD_WIDTH + 3;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    term_tag_t            tag_d_reg;
    logic                 vld_d_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] acc_reg;
    term_tag_t            tag_acc_reg;
    logic                 res_done_reg;

    assign diff      = DW'(corner) - DW'(point);
    assign prod_next = PW'(normal) * PW'(diff);
    assign acc_next  = (tag_d_reg.first ? AW'(0) : acc_reg) + AW'(prod_reg);

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_d_reg <= term_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        tag_d_reg <= term_tag;
    end

    // Accumulate stage; flag completion when the last term lands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_done_reg <= 1'b0;
        end
        else
        begin
            res_done_reg <= vld_d_reg && tag_d_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_d_reg)
        begin
            acc_reg     <= acc_next;
            tag_acc_reg <= tag_d_reg;
        end
    end

    assign res.done      = res_done_reg;
    assign res.negative  = acc_reg[AW-1];
    assign res.n_vertex  = tag_acc_reg.n_vertex;
    assign res.final_dot = tag_acc_reg.final_dot;

    a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d_reg && tag_d_reg.last |=> res_done_reg)
        else $error("dot result missing after last term");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_done_reg |-> $past(vld_d_reg))
        else $error("dot result without a product term");

endmodule

### design/ffbv_seq.sv
// Sequencer: walks planes, corners and axes through the shared unit.
module ffbv_seq #(
    parameter int PLANE_COUNT = ffbv_pkg::PLANE_COUNT_DEF,
    parameter int SLOT_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  ffbv_pkg::op_t                 op,
    output logic                          s_tready,
    output logic                          capture,
    output logic                          load_we,
    output logic                          term_valid,
    output ffbv_pkg::term_tag_t           term_tag,
    output logic [SLOT_W-1:0]             rd_slot,
    output logic [ffbv_pkg::AXIS_W-1:0]   rd_axis,
    input  ffbv_pkg::dot_res_t            res,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output ffbv_pkg::vis_t                vis
);
    import ffbv_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_PLANE = SLOT_W'(PLANE_COUNT - 1);

    state_t              state_reg,  state_next;
    logic [SLOT_W-1:0]   plane_reg,  plane_next;
    logic                nvert_reg,  nvert_next;
    logic [AXIS_W-1:0]   axis_reg,   axis_next;
    vis_t                vis_reg,    vis_next;
    logic                busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            nvert_reg <= 1'b0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            nvert_reg <= nvert_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
    end

    assign busy = (state_reg == ST_RUN) || (state_reg == ST_DRAIN);

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        nvert_next = nvert_reg;
        axis_next  = axis_reg;
        vis_next   = vis_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        capture    = 1'b0;
        load_we    = 1'b0;
        term_valid = 1'b0;

        term_tag.first     = (axis_reg == AXIS_X);
        term_tag.last      = (axis_reg == AXIS_Z);
        term_tag.n_vertex  = nvert_reg;
        term_tag.final_dot = (axis_reg == AXIS_Z) && nvert_reg && (plane_reg == LAST_PLANE);

        case (state_reg)
            ST_IDLE:
            begin
                // Ready is always high here, so valid alone marks a transfer.
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (op == OP_LOAD)
                    begin
                        load_we = 1'b1;
                    end
                    else
                    begin
                        capture    = 1'b1;
                        plane_next = '0;
                        nvert_next = 1'b0;
                        axis_next  = AXIS_X;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // Issue one product term; advance axis, then corner, then plane.
                term_valid = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    nvert_next = !nvert_reg;
                    if (nvert_reg)
                    begin
                        if (plane_reg == LAST_PLANE)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            plane_next = plane_reg + SLOT_W'(1);
                        end
                    end
                end
                else
                begin
                    axis_next = axis_reg + AXIS_W'(1);
                end
            end
            ST_DRAIN:
            begin
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Exit on a negative distance, else visible on the final dot product.
        if (busy && res.done)
        begin
            if (res.negative)
            begin
                vis_next   = res.n_vertex ? VIS_PARTIAL : VIS_INVISIBLE;
                state_next = ST_OUT;
            end
            else if (res.final_dot)
            begin
                vis_next   = VIS_VISIBLE;
                state_next = ST_OUT;
            end
        end
    end

    assign rd_slot = plane_reg;
    assign rd_axis = axis_reg;
    assign vis     = vis_reg;

    a_no_accept_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_final_issue_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && term_tag.final_dot |=> state_reg == ST_DRAIN || state_reg == ST_OUT)
        else $error("issue continued past the last term");

    a_negative_exits: assert property (@(posedge clk) disable iff (!rst_n)
        busy && res.done && res.negative |=> m_tvalid)
        else $error("negative distance did not end the test");

endmodule

### design/frustum_box_visibility_test_top.sv
// Top level of the frustum box visibility test.
// Flow: a test's product terms pass the product and accumulate stages of the dot unit; m_tvalid
// rises once the result is decided and stays high until m_tready; the sequence stops at the
// first plane with a negative distance.
// Throughput: one shared multiplier takes one product term per cycle, six terms per plane,
// while a test runs; a test or load is accepted only when idle, once any earlier result has transferred.
// Reset: rst_n is asynchronous, active low; it clears the sequencer's state and counters and all planes.
module frustum_box_visibility_test_top #(
    parameter int PLANE_COUNT = ffbv_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = ffbv_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, low bit up: plane_slot[2:0], coord_a_x, coord_a_y, coord_a_z,
    // coord_b_x, coord_b_y, coord_b_z (32 bits each), zero pad
    input  logic [ffbv_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation (0 test a box, 1 load a plane)
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: visibility[1:0], zero pad
    output logic [ffbv_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ffbv_pkg::*;

    localparam int SLOT_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // Coordinates of the item at the input, low COORD_WIDTH bits of each field.
    logic signed [COORD_WIDTH-1:0] coord_a_in [3];
    logic signed [COORD_WIDTH-1:0] coord_b_in [3];
    logic [SLOT_FIELD_W-1:0]       plane_slot;

    // Box corners held for the duration of a test.
    logic signed [COORD_WIDTH-1:0] box_a_reg [3];
    logic signed [COORD_WIDTH-1:0] box_b_reg [3];

    logic                          capture;
    logic                          load_we;
    logic                          term_valid;
    term_tag_t                     term_tag;
    logic [SLOT_W-1:0]             rd_slot;
    logic [AXIS_W-1:0]             rd_axis;
    logic signed [COORD_WIDTH-1:0] rd_point;
    logic signed [COORD_WIDTH-1:0] rd_normal;
    logic signed [COORD_WIDTH-1:0] corner;
    dot_res_t                      res;
    vis_t                          vis;

    assign plane_slot = s_tdata[SLOT_FIELD_W-1:0];

    for (genvar a = 0; a < 3; a++)
    begin : g_unpack
        assign coord_a_in[a] = s_tdata[COORD_LSB + a * FIELD_W +: COORD_WIDTH];
        assign coord_b_in[a] = s_tdata[COORD_LSB + (a + 3) * FIELD_W +: COORD_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            box_a_reg <= coord_a_in;
            box_b_reg <= coord_b_in;
        end
    end

    // Far corner takes the maximum where the normal is non-negative, the minimum
    // otherwise; the near corner takes the opposite.
    assign corner = (rd_normal[COORD_WIDTH-1] ^ term_tag.n_vertex) ?
                    box_a_reg[rd_axis] : box_b_reg[rd_axis];

    ffbv_seq #(
        .PLANE_COUNT (PLANE_COUNT),
        .SLOT_W      (SLOT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .op         (op_t'(s_tuser)),
        .s_tready   (s_tready),
        .capture    (capture),
        .load_we    (load_we),
        .term_valid (term_valid),
        .term_tag   (term_tag),
        .rd_slot    (rd_slot),
        .rd_axis    (rd_axis),
        .res        (res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .vis        (vis)
    );

    ffbv_plane_store #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH),
        .SLOT_W      (SLOT_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .we        (load_we),
        .load_slot (plane_slot),
        .wr_point  (coord_a_in),
        .wr_normal (coord_b_in),
        .rd_slot   (rd_slot),
        .rd_axis   (rd_axis),
        .rd_point  (rd_point),
        .rd_normal (rd_normal)
    );

    ffbv_dot_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (term_valid),
        .term_tag   (term_tag),
        .corner     (corner),
        .point      (rd_point),
        .normal     (rd_normal),
        .res        (res)
    );

    assign m_tdata = {{(M_TDATA_W - VIS_W){1'b0}}, vis};

endmodule
